// File: rtl/bilinear_texture_sampler_unit_assert.svh
// ----------------------------------------------------------------------------
// Bilinear texture sampler assertion macros
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication
`define BTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Widths, bank layout, stage control types and the blend function.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Field widths
    localparam int ADDR_W       = 18;
    localparam int COORD_W      = 16;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 3;
    localparam int TEXEL_W      = NUM_CHAN * CHAN_W;

    // Square texture filling the whole store
    localparam int SIDE_W       = ADDR_W / 2;
    localparam int TEXTURE_SIDE = 1 << SIDE_W;

    // Blend weight
    localparam int FRAC_W       = 7;
    localparam int FRAC_ONE     = 1 << FRAC_W;

    // Four banks split by row and column parity
    localparam int NUM_BANKS    = 4;
    localparam int BANK_AW      = ADDR_W - 2;
    localparam int BANK_DEPTH   = 1 << BANK_AW;

    typedef enum logic
    {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    typedef logic [CHAN_W-1:0]                    chan_t;
    typedef logic [TEXEL_W-1:0]                   texel_t;
    typedef logic [FRAC_W-1:0]                    frac_t;
    typedef logic [1:0]                           bank_sel_t;
    typedef logic [NUM_BANKS-1:0][TEXEL_W-1:0]    bank_data_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]      chan_vec_t;

    // Control travelling alongside the bank read data
    typedef struct packed
    {
        logic      valid;
        frac_t     frac_u;
        frac_t     frac_v;
        bank_sel_t sel00;
        bank_sel_t sel10;
        bank_sel_t sel01;
        bank_sel_t sel11;
    } tap_ctl_t;

    // One linear blend step with truncation
    function automatic chan_t lerp8(chan_t a, chan_t b, frac_t f);
        logic [FRAC_W:0]            wa;
        logic [CHAN_W+FRAC_W-1:0]   pa;
        logic [CHAN_W+FRAC_W-1:0]   pb;
        logic [CHAN_W+FRAC_W:0]     sum;
        wa  = (FRAC_W+1)'(FRAC_ONE) - {1'b0, f};
        pa  = {{FRAC_W{1'b0}}, a} * {{(CHAN_W-1){1'b0}}, wa};
        pb  = {{FRAC_W{1'b0}}, b} * {{CHAN_W{1'b0}}, f};
        sum = {1'b0, pa} + {1'b0, pb};
        return sum[FRAC_W +: CHAN_W];
    endfunction

endpackage

// File: rtl/bilinear_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler unit
// A sample transfer passes the bank read, the u blend and the v blend into the
// output register in turn; a write gives no result.
// Throughput: one item per cycle while out_ready does not hold the output, set
// by the four parity banks that deliver all four neighbours in a single read.
// Reset clears the pipeline valids only; the texel store is not cleared.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_unit_assert.svh"

module bilinear_texture_sampler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [bts_pkg::ADDR_W-1:0]    texel_address,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_red,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_green,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_blue,
    input  logic [bts_pkg::COORD_W-1:0]   coord_u,
    input  logic [bts_pkg::COORD_W-1:0]   coord_v,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bts_pkg::CHAN_W-1:0]    sample_red,
    output logic [bts_pkg::CHAN_W-1:0]    sample_green,
    output logic [bts_pkg::CHAN_W-1:0]    sample_blue
);
    import bts_pkg::*;

    logic       accept;
    logic       tap_take;
    bank_data_t tap_data;
    tap_ctl_t   tap_ctl;

    // Take a transfer whenever the fetch stage can move on
    assign in_ready = !tap_ctl.valid || tap_take;
    assign accept   = in_valid && in_ready;

    bts_fetch u_fetch (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_ready),
        .accept        (accept),
        .mode          (mode),
        .texel_address (texel_address),
        .texel_red     (texel_red),
        .texel_green   (texel_green),
        .texel_blue    (texel_blue),
        .coord_u       (coord_u),
        .coord_v       (coord_v),
        .tap_data      (tap_data),
        .tap_ctl       (tap_ctl)
    );

    bts_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_ctl      (tap_ctl),
        .tap_data     (tap_data),
        .tap_take     (tap_take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue)
    );

    // A sample enters the fetch stage, a write never does
    `BTS_ASSERT_NEXT(a_sample_enters_tap, accept && (mode_t'(mode) == MODE_SAMPLE), tap_ctl.valid, "sample transfer lost before blend")
    `BTS_ASSERT_NEXT(a_write_no_tap, accept && (mode_t'(mode) == MODE_WRITE), !tap_ctl.valid, "write transfer produced a sample")
    // A stalled fetch stage keeps its bank read data
    `BTS_ASSERT_NEXT(a_tap_holds, tap_ctl.valid && !tap_take, tap_ctl.valid && $stable(tap_data), "bank read data changed under stall")

endmodule

// File: rtl/bts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with a registered read port.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read and hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bts_fetch.sv
// ----------------------------------------------------------------------------
// Texel fetch stage
// Splits the coordinates, addresses the four parity banks and registers the
// neighbour selection that goes with the read data.
// ----------------------------------------------------------------------------
module bts_fetch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [bts_pkg::ADDR_W-1:0]    texel_address,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_red,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_green,
    input  logic [bts_pkg::CHAN_W-1:0]    texel_blue,
    input  logic [bts_pkg::COORD_W-1:0]   coord_u,
    input  logic [bts_pkg::COORD_W-1:0]   coord_v,
    output bts_pkg::bank_data_t           tap_data,
    output bts_pkg::tap_ctl_t             tap_ctl
);
    import bts_pkg::*;

    logic              is_sample;
    logic [SIDE_W-1:0] u0, u0n, v0, v0n;
    frac_t             fu, fv;
    logic              clamp_u, clamp_v;
    logic              pu1, pv1;
    logic [SIDE_W-1:0] wr_row, wr_col;
    texel_t            wr_texel;

    logic              valid_reg;
    frac_t             frac_u_reg, frac_v_reg;
    bank_sel_t         sel00_reg, sel10_reg, sel01_reg, sel11_reg;

    // Split coordinates into index and weight
    assign is_sample = (mode_t'(mode) == MODE_SAMPLE);
    assign u0        = coord_u[COORD_W-1 -: SIDE_W];
    assign v0        = coord_v[COORD_W-1 -: SIDE_W];
    assign fu        = coord_u[COORD_W-SIDE_W-1 -: FRAC_W];
    assign fv        = coord_v[COORD_W-SIDE_W-1 -: FRAC_W];
    assign u0n       = u0 + 1'b1;
    assign v0n       = v0 + 1'b1;
    assign clamp_u   = (u0 == SIDE_W'(TEXTURE_SIDE - 1));
    assign clamp_v   = (v0 == SIDE_W'(TEXTURE_SIDE - 1));

    // A clamped neighbour reuses the bank of the base texel
    assign pu1       = u0[0] ^ ~clamp_u;
    assign pv1       = v0[0] ^ ~clamp_v;

    assign wr_row    = texel_address[ADDR_W-1 -: SIDE_W];
    assign wr_col    = texel_address[SIDE_W-1:0];
    assign wr_texel  = {texel_red, texel_green, texel_blue};

    // One bank per row and column parity
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic ROW_PAR = 1'((b >> 1) & 1);
        localparam logic COL_PAR = 1'(b & 1);

        logic [SIDE_W-1:0]  row_rd, col_rd;
        logic               wr_hit;
        logic               bank_en, bank_we;
        logic [BANK_AW-1:0] bank_addr;

        assign row_rd    = (u0[0] == ROW_PAR) ? u0 : u0n;
        assign col_rd    = (v0[0] == COL_PAR) ? v0 : v0n;
        assign wr_hit    = (wr_row[0] == ROW_PAR) && (wr_col[0] == COL_PAR);
        assign bank_en   = accept && (is_sample || wr_hit);
        assign bank_we   = accept && !is_sample && wr_hit;
        assign bank_addr = is_sample ? {row_rd[SIDE_W-1:1], col_rd[SIDE_W-1:1]}
                                     : {wr_row[SIDE_W-1:1], wr_col[SIDE_W-1:1]};

        bts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .en    (bank_en),
            .we    (bank_we),
            .addr  (bank_addr),
            .wdata (wr_texel),
            .rdata (tap_data[b])
        );
    end

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= accept && is_sample;
        end
    end

    // Hold weights and neighbour selection next to the read data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frac_u_reg <= fu;
            frac_v_reg <= fv;
            sel00_reg  <= {u0[0], v0[0]};
            sel10_reg  <= {pu1,   v0[0]};
            sel01_reg  <= {u0[0], pv1};
            sel11_reg  <= {pu1,   pv1};
        end
    end

    assign tap_ctl = '{valid:  valid_reg,
                       frac_u: frac_u_reg,
                       frac_v: frac_v_reg,
                       sel00:  sel00_reg,
                       sel10:  sel10_reg,
                       sel01:  sel01_reg,
                       sel11:  sel11_reg};

endmodule

// File: rtl/bts_blend.sv
// ----------------------------------------------------------------------------
// Bilinear blend pipeline
// Blends along u in the first stage and along v into the output register.
// ----------------------------------------------------------------------------
module bts_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bts_pkg::tap_ctl_t           tap_ctl,
    input  bts_pkg::bank_data_t         tap_data,
    output logic                        tap_take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bts_pkg::CHAN_W-1:0]  sample_red,
    output logic [bts_pkg::CHAN_W-1:0]  sample_green,
    output logic [bts_pkg::CHAN_W-1:0]  sample_blue
);
    import bts_pkg::*;

    texel_t    t00, t10, t01, t11;
    chan_vec_t row_a_next, row_b_next, pix_next;
    logic      out_load, p1_free;

    logic      p1_valid_reg;
    chan_vec_t row_a_reg, row_b_reg;
    frac_t     frac_v_reg;
    logic      out_valid_reg;
    chan_vec_t pix_reg;

    // Pick the four neighbours out of the banks
    assign t00 = tap_data[tap_ctl.sel00];
    assign t10 = tap_data[tap_ctl.sel10];
    assign t01 = tap_data[tap_ctl.sel01];
    assign t11 = tap_data[tap_ctl.sel11];

    // Stage flow: load the output when it is empty or being taken
    assign out_load = !out_valid_reg || out_ready;
    assign p1_free  = !p1_valid_reg || out_load;
    assign tap_take = p1_free;

    // Blend each channel along u, then along v
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            row_a_next[c] = lerp8(t00[c*CHAN_W +: CHAN_W], t10[c*CHAN_W +: CHAN_W],
                                  tap_ctl.frac_u);
            row_b_next[c] = lerp8(t01[c*CHAN_W +: CHAN_W], t11[c*CHAN_W +: CHAN_W],
                                  tap_ctl.frac_u);
            pix_next[c]   = lerp8(row_a_reg[c], row_b_reg[c], frac_v_reg);
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_free)
            begin
                p1_valid_reg <= tap_ctl.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Hold stage payloads while stalled
    always_ff @(posedge clk)
    begin
        if (p1_free)
        begin
            row_a_reg  <= row_a_next;
            row_b_reg  <= row_b_next;
            frac_v_reg <= tap_ctl.frac_v;
        end
        if (out_load)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_red   = pix_reg[2];
    assign sample_green = pix_reg[1];
    assign sample_blue  = pix_reg[0];

endmodule
